// File: rtl/core/tvlse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvlse_pkg: shared definitions for the three-valued logic stack evaluator
// Sizes, opcode and state encodings, the command struct between controller
// and datapath, and the Kleene logic functions.
// ----------------------------------------------------------------------------
package tvlse_pkg;

	// sizes
	localparam int MAX_PROGRAM  = 64;
	localparam int MAX_PORTS    = 16;
	localparam int PACKED_PORTS = 16;
	localparam int PC_W         = $clog2(MAX_PROGRAM);
	localparam int LEN_W        = $clog2(MAX_PROGRAM + 1);

	// field widths
	localparam int ENTRY_W  = 6;
	localparam int OP_W     = 3;
	localparam int PORT_W   = 6;
	localparam int VALS_W   = 32;
	localparam int PCNT_W   = 5;
	localparam int CFG_W    = 7;
	localparam int LV_W     = 2;
	localparam int PROG_W   = OP_W + PORT_W;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 8;

	// logic values
	localparam logic [LV_W-1:0] LV_ZERO = 2'd0;
	localparam logic [LV_W-1:0] LV_ONE  = 2'd1;
	localparam logic [LV_W-1:0] LV_UNK  = 2'd2;

	// command codes carried in tuser
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_PORT = 3'd0,
		OP_ZERO = 3'd1,
		OP_ONE  = 3'd2,
		OP_NOT  = 3'd3,
		OP_AND  = 3'd4,
		OP_OR   = 3'd5,
		OP_XOR  = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_wr;
		logic start;
		logic step_pc;
		logic exec;
		logic out_load;
	} cmd_t;

	function automatic logic [LV_W-1:0] lv_not(input logic [LV_W-1:0] a);
		lv_not = (a == LV_UNK) ? LV_UNK : (a ^ LV_ONE);
	endfunction

	function automatic logic [LV_W-1:0] lv_and(input logic [LV_W-1:0] a,
		input logic [LV_W-1:0] b);
		if (a == LV_ZERO || b == LV_ZERO) lv_and = LV_ZERO;
		else if (a == LV_ONE && b == LV_ONE) lv_and = LV_ONE;
		else lv_and = LV_UNK;
	endfunction

	function automatic logic [LV_W-1:0] lv_or(input logic [LV_W-1:0] a,
		input logic [LV_W-1:0] b);
		if (a == LV_ONE || b == LV_ONE) lv_or = LV_ONE;
		else if (a == LV_ZERO && b == LV_ZERO) lv_or = LV_ZERO;
		else lv_or = LV_UNK;
	endfunction

	function automatic logic [LV_W-1:0] lv_xor(input logic [LV_W-1:0] a,
		input logic [LV_W-1:0] b);
		lv_xor = (a == LV_UNK || b == LV_UNK) ? LV_UNK : (a ^ b);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/tvlse_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvlse_ram: generic simple dual-port ram
// One write port, one read port with registered read data (old data on a
// same-address write).
// ----------------------------------------------------------------------------
module tvlse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/tvlse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvlse_ctrl: evaluator controller
// Sequences load and evaluate commands, counts program entries, holds the
// program length register and the output valid flag.
// ----------------------------------------------------------------------------
module tvlse_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	input  wire logic                       command,
	input  wire logic                       cfg_valid,
	input  wire logic [tvlse_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       m_tready,
	output logic                            s_tready,
	output logic                            cfg_ready,
	output logic                            m_tvalid,
	output tvlse_pkg::cmd_t                 cmd
);

	import tvlse_pkg::*;

	state_t           state_q, state_n;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             take;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign out_free  = !out_valid_q || m_tready;
	assign take      = (state_q == ST_IDLE) && s_tvalid;

	// program length register, saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_valid) begin
			if (LEN_W'(cfg_data) > LEN_W'(MAX_PROGRAM)) len_q <= LEN_W'(MAX_PROGRAM);
			else len_q <= LEN_W'(cfg_data);
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && command == CMD_EVAL) begin
					state_n = (len_q == '0) ? ST_DONE : ST_FETCH;
				end
			end
			ST_FETCH: state_n = ST_EXEC;
			ST_EXEC: begin
				if (cnt_q == LEN_W'(1)) state_n = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_wr = take && command == CMD_LOAD;
				cmd.start   = take && command == CMD_EVAL;
			end
			ST_FETCH: cmd.step_pc = 1'b1;
			ST_EXEC: begin
				cmd.step_pc = 1'b1;
				cmd.exec    = 1'b1;
			end
			ST_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	// state, entry counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.start) cnt_q <= len_q;
			else if (cmd.exec) cnt_q <= cnt_q - LEN_W'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_exec_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && cnt_q == LEN_W'(1)) |=> state_q == ST_DONE)
		else $error("evaluation did not end after last entry");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_free) |=> state_q == ST_DONE && out_valid_q)
		else $error("finished result dropped while output busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> (cnt_q != '0 && cnt_q <= len_q))
		else $error("entry counter out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/core/tvlse_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvlse_dp: evaluator datapath
// Program memory, value stack (top in a register, rest in memory with a
// write bypass), port decode, Kleene logic unit and the result register.
// ----------------------------------------------------------------------------
module tvlse_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tvlse_pkg::cmd_t                   cmd,
	input  wire logic        [tvlse_pkg::ENTRY_W-1:0] entry_index,
	input  wire logic        [tvlse_pkg::OP_W-1:0]    op_code,
	input  wire logic signed [tvlse_pkg::PORT_W-1:0]  op_port,
	input  wire logic        [tvlse_pkg::VALS_W-1:0]  pin_vals,
	input  wire logic        [tvlse_pkg::PCNT_W-1:0]  port_count,
	output logic             [tvlse_pkg::LV_W-1:0]    logic_result
);

	import tvlse_pkg::*;

	logic [PC_W-1:0]   pc_q;
	logic [LEN_W-1:0]  lvl_q, lvl_n;
	logic [LV_W-1:0]   tos_q, tos_n;
	logic [LV_W-1:0]   byp_q;
	logic              byp_hit_q;
	logic [VALS_W-1:0] vals_q;
	logic [PCNT_W-1:0] pcnt_q;
	logic [LV_W-1:0]   out_q;

	logic [PROG_W-1:0] prog_rd;
	logic              prog_we;
	logic [LV_W-1:0]   stk_rd;
	logic              stk_we;
	logic [PC_W-1:0]   stk_waddr;
	logic [PC_W-1:0]   stk_raddr;

	opcode_t           op;
	logic [PORT_W-1:0] pb;
	logic [4:0]        pidx;
	logic [LV_W-1:0]   pcode;
	logic [LV_W-1:0]   port_lv;
	logic [LV_W-1:0]   push_v;
	logic [LV_W-1:0]   nos;
	logic [LV_W-1:0]   arg_a, arg_b;
	logic              has1, has2, full;

	// program memory
	assign prog_we = cmd.load_wr && (int'(entry_index) < MAX_PROGRAM);

	tvlse_ram #(
		.WIDTH(PROG_W),
		.DEPTH(MAX_PROGRAM)
	) u_prog (
		.clk  (clk),
		.we   (prog_we),
		.waddr(PC_W'(entry_index)),
		.wdata({op_code, op_port}),
		.raddr(pc_q),
		.rdata(prog_rd)
	);

	// value stack below the top entry
	tvlse_ram #(
		.WIDTH(LV_W),
		.DEPTH(MAX_PROGRAM)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(tos_q),
		.raddr(stk_raddr),
		.rdata(stk_rd)
	);

	// entry decode and port read
	assign op      = opcode_t'(prog_rd[PROG_W-1:PORT_W]);
	assign pb      = prog_rd[PORT_W-1:0];
	assign pidx    = pb[4:0];
	assign pcode   = vals_q[{pidx[3:0], 1'b0} +: LV_W];
	always_comb begin
		if (pb[PORT_W-1] || PCNT_W'(pidx) >= pcnt_q || int'(pidx) >= MAX_PORTS
			|| int'(pidx) >= PACKED_PORTS) begin
			port_lv = LV_UNK;
		end else begin
			port_lv = pcode[1] ? LV_UNK : pcode;
		end
	end

	// stack operands; an empty slot pops as unknown
	assign nos   = byp_hit_q ? byp_q : stk_rd;
	assign has1  = lvl_q != '0;
	assign has2  = lvl_q > LEN_W'(1);
	assign full  = lvl_q == LEN_W'(MAX_PROGRAM);
	assign arg_b = has1 ? tos_q : LV_UNK;
	assign arg_a = has2 ? nos : LV_UNK;

	// execute one entry
	always_comb begin
		lvl_n     = lvl_q;
		tos_n     = tos_q;
		stk_we    = 1'b0;
		stk_waddr = PC_W'(lvl_q - LEN_W'(1));
		push_v    = port_lv;
		if (cmd.exec) begin
			case (op)
				OP_PORT, OP_ZERO, OP_ONE: begin
					if (op == OP_ZERO) push_v = LV_ZERO;
					else if (op == OP_ONE) push_v = LV_ONE;
					if (!full) begin
						tos_n  = push_v;
						lvl_n  = lvl_q + LEN_W'(1);
						stk_we = has1;
					end
				end
				OP_NOT: begin
					tos_n = lv_not(arg_b);
					lvl_n = has1 ? lvl_q : LEN_W'(1);
				end
				OP_AND: begin
					tos_n = lv_and(arg_a, arg_b);
					lvl_n = has2 ? lvl_q - LEN_W'(1) : LEN_W'(1);
				end
				OP_OR: begin
					tos_n = lv_or(arg_a, arg_b);
					lvl_n = has2 ? lvl_q - LEN_W'(1) : LEN_W'(1);
				end
				OP_XOR: begin
					tos_n = lv_xor(arg_a, arg_b);
					lvl_n = has2 ? lvl_q - LEN_W'(1) : LEN_W'(1);
				end
				default: ;
			endcase
		end
	end

	// prefetch the entry under the new top
	assign stk_raddr = PC_W'(lvl_n - LEN_W'(2));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			lvl_q     <= '0;
			byp_hit_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				pc_q      <= '0;
				lvl_q     <= '0;
				byp_hit_q <= 1'b0;
			end else begin
				if (cmd.step_pc) pc_q <= pc_q + PC_W'(1);
				lvl_q     <= lvl_n;
				byp_hit_q <= stk_we;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			vals_q <= pin_vals;
			pcnt_q <= port_count;
		end
		tos_q <= tos_n;
		byp_q <= tos_q;
		if (cmd.out_load) begin
			out_q <= (lvl_q == LEN_W'(1)) ? tos_q : LV_UNK;
		end
	end

	assign logic_result = out_q;

`ifndef NO_ASSERTIONS
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LEN_W'(MAX_PROGRAM))
		else $error("stack level beyond depth");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (lvl_q == '0 && pc_q == '0 && !byp_hit_q))
		else $error("evaluation start did not clear stack");
	a_byp_push: assert property (@(posedge clk) disable iff (!arst_n)
		byp_hit_q |-> $past(cmd.exec) && lvl_q > LEN_W'(1))
		else $error("stack bypass without a push");
`endif

endmodule
`default_nettype wire

// File: rtl/core/three_valued_logic_stack_evaluator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_valued_logic_stack_evaluator_top: postfix Kleene logic evaluator
// Runs a stored postfix program over a stack of three-valued values.
//
//   channel | direction | handshake           | contents
//   s_      | in        | s_tvalid / s_tready | load or evaluate word
//   m_      | out       | m_tvalid / m_tready | evaluation result word
//   cfg_    | in        | cfg_valid/cfg_ready | program length
//
// A load word is written to program memory as it is taken. An evaluate
// word occupies the block until its result is loaded: the program memory
// has one read port, so one entry is fetched and executed per cycle.
// Reset clears the controller, stack level and program length; program
// memory contents are undefined until loaded.
// A finished result sits in the output register while new words are taken;
// the next evaluation waits at its end until that register is free.
// ----------------------------------------------------------------------------
module three_valued_logic_stack_evaluator_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// entry_index, op_code, op_port, pin_vals, port_count, zero fill
	input  wire logic [tvlse_pkg::IN_DATA_W-1:0]      s_tdata,
	// command
	input  wire logic                                 s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// logic_result, zero fill
	output logic      [tvlse_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [tvlse_pkg::CFG_W-1:0]          cfg_data
);

	import tvlse_pkg::*;

	cmd_t            cmd;
	logic [LV_W-1:0] logic_result;

	localparam int OFS_OP   = ENTRY_W;
	localparam int OFS_PORT = OFS_OP + OP_W;
	localparam int OFS_VALS = OFS_PORT + PORT_W;
	localparam int OFS_PCNT = OFS_VALS + VALS_W;

	tvlse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.command  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.m_tready (m_tready),
		.s_tready (s_tready),
		.cfg_ready(cfg_ready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	tvlse_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.entry_index (s_tdata[ENTRY_W-1:0]),
		.op_code     (s_tdata[OFS_OP +: OP_W]),
		.op_port     (s_tdata[OFS_PORT +: PORT_W]),
		.pin_vals    (s_tdata[OFS_VALS +: VALS_W]),
		.port_count  (s_tdata[OFS_PCNT +: PCNT_W]),
		.logic_result(logic_result)
	);

	// result word, zero filled
	assign m_tdata = {{(OUT_DATA_W - LV_W){1'b0}}, logic_result};

endmodule
`default_nettype wire

// File: bench/three_valued_logic_stack_evaluator_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_valued_logic_stack_evaluator_top_test: self-checking bench for the
// postfix Kleene logic evaluator
// Loads postfix programs, evaluates them with packed port values and checks
// every result word against a local evaluator that tracks the program store
// and program length. Directed checks come first: length zero, port reads,
// every operator, bad stack depth, an empty pop and the no-op code. Random
// phases follow, each setting its program length and one of four idle patterns.
// ----------------------------------------------------------------------------
module three_valued_logic_stack_evaluator_top_test;
	import tvlse_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 80;
	localparam int PHASE_WORDS   = 145;
	localparam int PHASE_COUNT   = 10;
	localparam int REPORT_MAX    = 10;
	localparam logic [OP_W-1:0]   OP_NOP          = 3'd7;
	localparam logic [PORT_W-1:0] PORT_UNRESOLVED = 6'h3F;

	// s_tdata layout, lowest bits first: entry, opcode, port, values, count
	typedef struct packed {
		logic [3:0]          fill;
		logic [PCNT_W-1:0]   count;
		logic [VALS_W-1:0]   values;
		logic [PORT_W-1:0]   port;
		logic [OP_W-1:0]     op;
		logic [ENTRY_W-1:0]  entry;
	} in_word_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data  = '0;

	// local copy of the program store and length
	logic [OP_W-1:0]   prog_op   [MAX_PROGRAM];
	logic [PORT_W-1:0] prog_port [MAX_PROGRAM];
	int                prog_len  = 0;

	// evaluation stack of the local evaluator
	logic [LV_W-1:0] eval_stack [MAX_PROGRAM];
	int              eval_depth = 0;

	logic [LV_W-1:0] expected_levels [$];
	int              gap_pct     = 0;
	int              stall_pct   = 0;
	int              error_count = 0;
	int              cycle_count = 0;

	three_valued_logic_stack_evaluator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= REPORT_MAX)
			$display("mismatch: %s", msg);
	endfunction

	// stack helpers of the local evaluator
	function automatic void push_level(input logic [LV_W-1:0] v);
		if (eval_depth < MAX_PROGRAM) begin
			eval_stack[eval_depth] = v;
			eval_depth++;
		end
	endfunction

	function automatic logic [LV_W-1:0] pop_level();
		if (eval_depth == 0)
			return LV_UNK;
		eval_depth--;
		return eval_stack[eval_depth];
	endfunction

	// negative, out of count or out of range ports read as unknown
	function automatic logic [LV_W-1:0] port_level(input logic [PORT_W-1:0] p,
		input logic [VALS_W-1:0] vals, input logic [PCNT_W-1:0] cnt);
		logic [1:0] code;
		if (p[PORT_W-1] || p[4:0] >= cnt || p[4:0] >= MAX_PORTS)
			return LV_UNK;
		code = 2'(vals >> (2 * p[3:0]));
		return code[1] ? LV_UNK : code;
	endfunction

	// run the stored program once
	function automatic logic [LV_W-1:0] evaluate_program(input logic [VALS_W-1:0] vals,
		input logic [PCNT_W-1:0] cnt);
		logic [LV_W-1:0] a;
		logic [LV_W-1:0] b;
		eval_depth = 0;
		for (int i = 0; i < prog_len; i++) begin
			case (prog_op[i])
				OP_PORT: push_level(port_level(prog_port[i], vals, cnt));
				OP_ZERO: push_level(LV_ZERO);
				OP_ONE:  push_level(LV_ONE);
				OP_NOT: begin
					a = pop_level();
					push_level((a == LV_UNK) ? LV_UNK : ((a == LV_ONE) ? LV_ZERO : LV_ONE));
				end
				OP_AND: begin
					b = pop_level();
					a = pop_level();
					if (a == LV_ZERO || b == LV_ZERO) push_level(LV_ZERO);
					else if (a == LV_ONE && b == LV_ONE) push_level(LV_ONE);
					else push_level(LV_UNK);
				end
				OP_OR: begin
					b = pop_level();
					a = pop_level();
					if (a == LV_ONE || b == LV_ONE) push_level(LV_ONE);
					else if (a == LV_ZERO && b == LV_ZERO) push_level(LV_ZERO);
					else push_level(LV_UNK);
				end
				OP_XOR: begin
					b = pop_level();
					a = pop_level();
					if (a == LV_UNK || b == LV_UNK) push_level(LV_UNK);
					else push_level((a == b) ? LV_ZERO : LV_ONE);
				end
				default: ;
			endcase
		end
		return (eval_depth == 1) ? eval_stack[0] : LV_UNK;
	endfunction

	// update the local state for one accepted word
	function automatic void apply_word(input logic cmd, input in_word_t w);
		if (cmd == CMD_LOAD) begin
			prog_op[w.entry]   = w.op;
			prog_port[w.entry] = w.port;
		end else begin
			expected_levels.insert(expected_levels.size(),
				evaluate_program(w.values, w.count));
		end
	endfunction

	// result check and receiver stalls
	always @(posedge clk) begin : check_results
		logic [LV_W-1:0] want;
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_levels.size() == 0) begin
				report_error($sformatf("result %0d with nothing pending", m_tdata[LV_W-1:0]));
			end else begin
				want = expected_levels.pop_front();
				if (m_tdata[LV_W-1:0] !== want)
					report_error($sformatf("logic_result expected %0d got %0d",
						want, m_tdata[LV_W-1:0]));
			end
		end
	end

	// send one word, with random idle cycles ahead of it
	task automatic send_word(input logic cmd, input in_word_t w);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		apply_word(cmd, w);
	endtask

	task automatic send_load(input logic [ENTRY_W-1:0] entry, input logic [OP_W-1:0] op,
		input logic [PORT_W-1:0] port);
		in_word_t w;
		w       = '0;
		w.entry = entry;
		w.op    = op;
		w.port  = port;
		send_word(CMD_LOAD, w);
	endtask

	task automatic send_eval(input logic [VALS_W-1:0] vals, input logic [PCNT_W-1:0] cnt);
		in_word_t w;
		w        = '0;
		w.values = vals;
		w.count  = cnt;
		send_word(CMD_EVAL, w);
	endtask

	// wait for every result, then let a trailing load finish
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_program_length(input int len);
		drain_and_settle();
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(len);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		prog_len = (len > MAX_PROGRAM) ? MAX_PROGRAM : len;
	endtask

	// mostly in range, some unresolved, some beyond the packed ports
	function automatic logic [PORT_W-1:0] random_port();
		int pick;
		pick = $urandom_range(9);
		if (pick < 8) return PORT_W'($urandom_range(15));
		if (pick == 8) return PORT_UNRESOLVED;
		return PORT_W'($urandom_range(31, 16));
	endfunction

	function automatic logic [OP_W-1:0] random_push_op();
		case ($urandom_range(3))
			0, 1:    return OP_PORT;
			2:       return OP_ZERO;
			default: return OP_ONE;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] random_binary_op();
		case ($urandom_range(2))
			0:       return OP_AND;
			1:       return OP_OR;
			default: return OP_XOR;
		endcase
	endfunction

	task automatic load_entry(input int idx, input logic [OP_W-1:0] op);
		send_load(ENTRY_W'(idx), op, (op == OP_PORT) ? random_port() : PORT_W'($urandom));
	endtask

	// depth d with r entries left can still end at depth one
	function automatic bit can_finish(input int d, input int r);
		if (r == 0) return d == 1;
		if (d == 0) return 1'b1;
		return d - 1 <= r;
	endfunction

	// load a well-formed postfix program into entries 0..n-1
	task automatic load_program(input int n);
		int depth;
		int kind;
		int next_depth;
		logic [OP_W-1:0] op;
		depth = 0;
		for (int i = 0; i < n; i++) begin
			do begin
				kind = $urandom_range(9);
				if (kind < 5) next_depth = depth + 1;
				else if (kind < 7) next_depth = depth - 1;
				else next_depth = depth;
			end while ((kind >= 5 && kind < 7 && depth < 2) ||
				(kind >= 7 && kind < 9 && depth < 1) || !can_finish(next_depth, n - i - 1));
			if (kind < 5) op = random_push_op();
			else if (kind < 7) op = random_binary_op();
			else if (kind < 9) op = OP_NOT;
			else op = OP_NOP;
			load_entry(i, op);
			depth = next_depth;
		end
	endtask

	// rewrite one entry with an opcode of the same stack effect
	task automatic mutate_entry(input int n);
		int idx;
		logic [OP_W-1:0] op;
		idx = $urandom_range(n - 1);
		if (prog_op[idx] inside {OP_PORT, OP_ZERO, OP_ONE}) op = random_push_op();
		else if (prog_op[idx] inside {OP_AND, OP_OR, OP_XOR}) op = random_binary_op();
		else op = ($urandom_range(1) == 0) ? OP_NOT : OP_NOP;
		load_entry(idx, op);
	endtask

	task automatic random_eval();
		send_eval($urandom, ($urandom_range(3) == 0) ? PCNT_W'(MAX_PORTS)
			: PCNT_W'($urandom_range(MAX_PORTS)));
	endtask

	// length zero straight after reset reads no entry
	task automatic test_length_zero_after_reset();
		send_eval($urandom, PCNT_W'(MAX_PORTS));
	endtask

	// port value codes, unresolved port and port count limit
	task automatic test_port_reads();
		set_program_length(3);
		send_load(0, OP_PORT, 6'd0);
		send_load(1, OP_PORT, PORT_UNRESOLVED);
		send_load(2, OP_OR, 6'd0);
		send_eval(32'h0000_0001, 5'd1);
		send_eval(32'h0000_0000, 5'd1);
		send_eval(32'h0000_0003, 5'd1);
		send_eval(32'h0000_0001, 5'd0);
	endtask

	// every operator in one chain, top port at and past the count
	task automatic test_operator_chain();
		set_program_length(8);
		send_load(0, OP_PORT, 6'd15);
		send_load(1, OP_ONE, 6'd0);
		send_load(2, OP_AND, 6'd0);
		send_load(3, OP_NOT, 6'd0);
		send_load(4, OP_ZERO, 6'd0);
		send_load(5, OP_OR, 6'd0);
		send_load(6, OP_ONE, 6'd0);
		send_load(7, OP_XOR, 6'd0);
		send_eval(32'h4000_0000, 5'd16);
		send_eval(32'h4000_0000, 5'd15);
		send_eval(32'h0000_0000, 5'd16);
		send_eval(32'hFFFF_FFFF, 5'd16);
	endtask

	// final depth two, pop of an empty stack, no-op opcode
	task automatic test_malformed_stack();
		send_load(8, OP_ONE, 6'd0);
		set_program_length(9);
		send_eval(32'h4000_0000, 5'd16);
		send_load(0, OP_NOT, 6'd0);
		send_load(1, OP_ZERO, 6'd0);
		send_load(2, OP_AND, 6'd0);
		send_load(3, OP_NOP, 6'd0);
		set_program_length(4);
		send_eval($urandom, 5'd16);
	endtask

	function automatic int phase_length(input int p);
		case (p)
			0:       return 5;
			1:       return 127;
			2:       return 1;
			3:       return 12;
			4:       return MAX_PROGRAM;
			5:       return 3;
			6:       return 0;
			7:       return 8;
			8:       return MAX_PROGRAM + 1;
			default: return 20;
		endcase
	endfunction

	// random phases: well-formed programs with random ports, some noise
	task automatic test_random_programs();
		int active;
		int words;
		int pick;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_program_length(phase_length(p));
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 62; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 62; end
				default: begin gap_pct = 33; stall_pct = 33; end
			endcase
			active = prog_len;
			load_program(active);
			words = active;
			while (words < PHASE_WORDS) begin
				pick = $urandom_range(99);
				if (pick < 20 && active > 0) begin
					mutate_entry(active);
					words++;
				end else if (pick < 28) begin
					send_load(ENTRY_W'($urandom_range(63)), OP_W'($urandom), PORT_W'($urandom));
					words++;
				end else if (pick < 33 && active > 0 && active <= 16) begin
					load_program(active);
					words += active;
				end else begin
					random_eval();
					words++;
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_length_zero_after_reset();
		test_port_reads();
		test_operator_chain();
		test_malformed_stack();
		test_random_programs();
		drain_and_settle();
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
